FILE: sv/md4_pkg.sv
// md4_pkg: constants, op codes and round tables for the md4 digest block
// no dependencies
package md4_pkg;

	typedef enum logic [1:0] {
		OP_ABSORB  = 2'd0,
		OP_DIGEST  = 2'd1,
		OP_RESTART = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] K2 = 32'h5a827999;
	localparam logic [31:0] K3 = 32'h6ed9eba1;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int BLOCK_BYTES = 64;

	// message word index used by step i
	function automatic logic [3:0] word_sel(input logic [5:0] i);
		logic [3:0] k;
		k = i[3:0];
		if (i < 6'd16) return k;
		else if (i < 6'd32) return {k[1:0], k[3:2]};
		else return {k[0], k[1], k[2], k[3]};
	endfunction

	function automatic logic [4:0] shift_sel(input logic [5:0] i);
		logic [1:0] j;
		j = i[1:0];
		if (i < 6'd16) begin
			case (j)
				2'd0: return 5'd3;
				2'd1: return 5'd7;
				2'd2: return 5'd11;
				default: return 5'd19;
			endcase
		end else if (i < 6'd32) begin
			case (j)
				2'd0: return 5'd3;
				2'd1: return 5'd5;
				2'd2: return 5'd9;
				default: return 5'd13;
			endcase
		end else begin
			case (j)
				2'd0: return 5'd3;
				2'd1: return 5'd9;
				2'd2: return 5'd11;
				default: return 5'd15;
			endcase
		end
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
		logic [63:0] w;
		w = {v, v} << n;
		return w[63:32];
	endfunction

endpackage

FILE: sv/md4_message_digest.sv
// md4_message_digest: md4 hash of a byte stream, digest read without disturbing state
// depends on md4_pkg
//
// usage: s_tdata carries {data_byte, op}; op 0 absorbs a byte, 1 reads the digest,
// 2 restarts at the initial vector, 3 is ignored.
// bytes live in a 16 x 32-bit word memory; a digest read pads a private copy in a
// second word memory. each compression step primes a read of its message word from
// a memory with a registered read, then updates; after the 48 steps the add state
// folds the result into the chain.
// after an absorb the input is ready for the next byte, except after the 64th
// byte of a block, when it is held off while the block compresses.
// a digest read copies and pads the buffer in one pass and compresses it; with 56 or
// more bytes buffered a second padded block follows. the first word on m_tdata, with
// word_index and last_word in m_tuser and m_tlast, appears once the last padded
// block is folded into the digest chain.
// if the receiver stalls, the current word holds; no input is taken until all four
// words are taken.
// reset loads the initial vector into the chaining words and clears the bit count and
// fill index; the byte buffer is undefined until written.
module md4_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // op[1:0], data_byte[9:2], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // digest_word[31:0]
	output logic [1:0]  m_tuser,   // word_index[1:0]
	output logic        m_tlast    // last_word
);
	import md4_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_COPY  = 7'b0000010,
		ST_PAD   = 7'b0000100,
		ST_COMP  = 7'b0001000,
		ST_ADD   = 7'b0010000,
		ST_OUT   = 7'b0100000,
		ST_ZERO  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [31:0] msg_mem [16];   // stream block
	logic [31:0] pad_mem [16];   // padded copy
	logic [31:0] msg_rd_q, pad_rd_q;
	logic [31:0] h_q [4];
	logic [31:0] hd_q [4];       // digest working chain
	logic [31:0] v_q [4];
	logic [63:0] bit_count_q;
	logic [5:0]  fill_q;
	logic [5:0]  step_q;
	logic [4:0]  cnt_q;          // copy / pad word counter
	logic        use_pad_q;      // compressing the digest copy
	logic        second_q;       // digest needs a second block
	logic [1:0]  out_idx_q;
	logic        rd_valid_q;

	logic [1:0] op;
	logic [7:0] data_byte;
	logic       s_acc;
	assign op = s_tdata[1:0];
	assign data_byte = s_tdata[9:2];
	assign s_acc = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	// read address for the step engine and copy
	logic [3:0] rd_addr;
	always_comb begin
		if (state_q == ST_COMP) rd_addr = word_sel(step_q);
		else rd_addr = cnt_q[3:0];
	end

	// byte lane write into the stream word memory
	logic [31:0] cur_word_q;     // word being assembled
	logic [31:0] new_word;
	always_comb begin
		new_word = cur_word_q;
		case (fill_q[1:0])
			2'd0: new_word = {24'd0, data_byte};
			2'd1: new_word[15:8] = data_byte;
			2'd2: new_word[23:16] = data_byte;
			default: new_word[31:24] = data_byte;
		endcase
	end

	// padded word for the word read in the previous cycle (index cnt_q - 1)
	logic [3:0]  pw_idx;
	logic [31:0] pad_word;
	logic [3:0]  fw;
	assign pw_idx = cnt_q[3:0] - 4'd1;
	assign fw = fill_q[5:2];
	always_comb begin
		pad_word = 32'd0;
		if (!second_q) begin
			if (pw_idx < fw) pad_word = msg_rd_q;
			else if (pw_idx == fw) begin
				case (fill_q[1:0])
					2'd0: pad_word = {24'd0, PAD_BYTE};
					2'd1: pad_word = {16'd0, PAD_BYTE, msg_rd_q[7:0]};
					2'd2: pad_word = {8'd0, PAD_BYTE, msg_rd_q[15:0]};
					default: pad_word = {PAD_BYTE, msg_rd_q[23:0]};
				endcase
			end
		end
		if (second_q || fill_q < 6'd56) begin
			if (pw_idx == 4'd14) pad_word = bit_count_q[31:0];
			if (pw_idx == 4'd15) pad_word = bit_count_q[63:32];
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && op == OP_ABSORB) msg_mem[fill_q[5:2]] <= new_word;
		if ((state_q == ST_COPY || state_q == ST_PAD) && cnt_q != 5'd0)
			pad_mem[pw_idx] <= pad_word;
		msg_rd_q <= msg_mem[rd_addr];
		pad_rd_q <= pad_mem[rd_addr];
	end

	// round step
	logic [1:0]  t;
	logic [31:0] b, c, d, f, va, vn;
	logic [31:0] x;
	assign t = 2'd0 - step_q[1:0];
	assign b = v_q[t + 2'd1];
	assign c = v_q[t + 2'd2];
	assign d = v_q[t + 2'd3];
	assign x = use_pad_q ? pad_rd_q : msg_rd_q;
	always_comb begin
		if (step_q < 6'd16) f = ((b & c) | (~b & d));
		else if (step_q < 6'd32) f = ((b & c) | (b & d) | (c & d)) + K2;
		else f = (b ^ c ^ d) + K3;
		va = v_q[t] + f + x;
		vn = rotl(va, shift_sel(step_q));
	end

	logic [5:0] step_m1;
	assign step_m1 = step_q - 6'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			h_q <= '{IV0, IV1, IV2, IV3};
			hd_q <= '{default: '0};
			v_q <= '{default: '0};
			cur_word_q <= '0;
			bit_count_q <= '0;
			fill_q <= '0;
			step_q <= '0;
			cnt_q <= '0;
			use_pad_q <= 1'b0;
			second_q <= 1'b0;
			out_idx_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						case (op)
							OP_ABSORB: begin
								cur_word_q <= new_word;
								bit_count_q <= bit_count_q + 64'd8;
								fill_q <= fill_q + 6'd1;
								if (fill_q == 6'(BLOCK_BYTES - 1)) begin
									state_q <= ST_COMP;
									v_q <= h_q;
									hd_q <= h_q;
									use_pad_q <= 1'b0;
									step_q <= '0;
									rd_valid_q <= 1'b0;
								end
							end
							OP_DIGEST: begin
								state_q <= ST_COPY;
								hd_q <= h_q;
								cnt_q <= '0;
								second_q <= 1'b0;
							end
							OP_RESTART: begin
								h_q <= '{IV0, IV1, IV2, IV3};
								bit_count_q <= '0;
								fill_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_COPY, ST_PAD: begin
					// reads word cnt_q while padded word cnt_q-1 is written
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						state_q <= ST_COMP;
						v_q <= hd_q;
						use_pad_q <= 1'b1;
						step_q <= '0;
						rd_valid_q <= 1'b0;
					end
				end
				ST_COMP: begin
					// first cycle primes the memory read
					if (!rd_valid_q) begin
						rd_valid_q <= 1'b1;
					end else begin
						v_q[t] <= vn;
						step_q <= step_q + 6'd1;
						rd_valid_q <= 1'b0;
						if (step_q == 6'd47) state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 4; i++) hd_q[i] <= hd_q[i] + v_q[i];
					if (!use_pad_q) begin
						for (int i = 0; i < 4; i++) h_q[i] <= h_q[i] + v_q[i];
						state_q <= ST_IDLE;
					end else if (!second_q && fill_q >= 6'd56) begin
						second_q <= 1'b1;
						cnt_q <= '0;
						state_q <= ST_PAD;
					end else begin
						out_idx_q <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						out_idx_q <= out_idx_q + 2'd1;
						if (out_idx_q == 2'd3) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = hd_q[out_idx_q];
	assign m_tuser = out_idx_q;
	assign m_tlast = (out_idx_q == 2'd3);

	// step_m1 only names the previous step for the check below
`ifndef NO_ASSERTIONS
	a_step_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP && rd_valid_q && step_q != 6'd47) |=>
		(step_m1 == $past(step_q))) else $error("step did not advance");
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready) else $error("input taken while busy");
	a_out_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 2'd1))
		else $error("digest words out of order");
`endif
endmodule

FILE: bench/md4_message_digest_tb.sv
// md4_message_digest_tb: self-checking bench for the md4 byte-stream digest block
// predicts digests with its own md4 model; depends on md4_pkg and md4_message_digest
module md4_message_digest_tb;
	import md4_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  index;
		logic        last;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	md4_message_digest dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] chain[4];
	logic [7:0]  buf_bytes[64];
	logic [63:0] msg_bits;
	logic [5:0]  fill;

	digest_beat_t pending_beats[$];
	int errors = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	bit sent_done = 1'b0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	function automatic logic [31:0] rol(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	task automatic md4_compress(inout logic [31:0] h[4], input logic [7:0] blk[64]);
		logic [31:0] x[16];
		logic [31:0] v[4];
		logic [31:0] b, c, d, f;
		int t, k, s, m;
		int sh1[4] = '{3, 7, 11, 19};
		int sh2[4] = '{3, 5, 9, 13};
		int sh3[4] = '{3, 9, 11, 15};
		for (int i = 0; i < 16; i++)
			x[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
		for (int i = 0; i < 4; i++) v[i] = h[i];
		for (int i = 0; i < 48; i++) begin
			t = (4 - (i & 3)) & 3;
			b = v[(t+1)&3]; c = v[(t+2)&3]; d = v[(t+3)&3];
			k = i & 15;
			if (i < 16) begin
				f = ((b & c) | (~b & d)) + x[k];
				s = sh1[i&3];
			end else if (i < 32) begin
				m = ((k & 3) << 2) | (k >> 2);
				f = ((b & c) | (b & d) | (c & d)) + x[m] + 32'h5a827999;
				s = sh2[i&3];
			end else begin
				m = ((k & 1) << 3) | ((k & 2) << 1) | ((k & 4) >> 1) | ((k & 8) >> 3);
				f = (b ^ c ^ d) + x[m] + 32'h6ed9eba1;
				s = sh3[i&3];
			end
			v[t] = rol(v[t] + f, s);
		end
		for (int i = 0; i < 4; i++) h[i] = h[i] + v[i];
	endtask

	task automatic restart_model();
		chain[0] = 32'h67452301; chain[1] = 32'hefcdab89;
		chain[2] = 32'h98badcfe; chain[3] = 32'h10325476;
		foreach (buf_bytes[i]) buf_bytes[i] = '0;
		msg_bits = '0;
		fill = '0;
	endtask

	task automatic predict_item(input logic [1:0] op, input logic [7:0] data);
		logic [31:0] h[4];
		logic [7:0]  blk[64];
		case (op)
			OP_ABSORB: begin
				buf_bytes[fill] = data;
				msg_bits += 64'd8;
				fill = fill + 6'd1;
				if (fill == 6'd0) md4_compress(chain, buf_bytes);
			end
			OP_RESTART: restart_model();
			OP_DIGEST: begin
				for (int i = 0; i < 4; i++) h[i] = chain[i];
				for (int i = 0; i < 64; i++) blk[i] = (i < fill) ? buf_bytes[i] : 8'h00;
				blk[fill] = PAD_BYTE;
				if (fill >= 6'd56) begin
					md4_compress(h, blk);
					foreach (blk[i]) blk[i] = 8'h00;
				end
				for (int i = 0; i < 8; i++) blk[56+i] = msg_bits[8*i +: 8];
				md4_compress(h, blk);
				for (int i = 0; i < 4; i++)
					pending_beats.push_back('{h[i], 2'(i), i == 3});
			end
			default: ;
		endcase
	endtask

	// one transaction on the input stream, with random idle bursts first
	task automatic send_item(input logic [1:0] op, input logic [7:0] data);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, data, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_item(op, data);
	endtask

	// receiver stalls in bursts
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		digest_beat_t want;
		if (m_tvalid && m_tready) begin
			if (pending_beats.size() == 0) begin
				report_mismatch("unexpected word", m_tdata, '0);
			end else begin
				want = pending_beats.pop_front();
				if (m_tdata !== want.word) report_mismatch("digest_word", m_tdata, want.word);
				if (m_tuser !== want.index)
					report_mismatch("word_index", 32'(m_tuser), 32'(want.index));
				if (m_tlast !== want.last)
					report_mismatch("last_word", 32'(m_tlast), 32'(want.last));
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("md4_message_digest verification failed");
			$finish;
		end
	end

	task automatic send_bytes(input int n);
		for (int i = 0; i < n; i++) send_item(OP_ABSORB, 8'($urandom));
	endtask

	task automatic test_directed();
		send_item(OP_DIGEST, 8'h00);         // empty message
		send_item(OP_ABSORB, 8'h00);
		send_item(OP_ABSORB, 8'hff);
		send_item(OP_ABSORB, 8'h55);
		send_item(OP_ABSORB, 8'haa);
		send_item(OP_DIGEST, 8'hff);
		send_item(OP_UNUSED, 8'h5a);         // unused op, ignored
		send_item(OP_DIGEST, 8'h00);
		send_item(OP_RESTART, 8'hff);
		send_item(OP_DIGEST, 8'h00);
	endtask

	// one message grown through lengths around the padding boundary and a full block
	task automatic test_padding_edges();
		int lens[6] = '{55, 56, 63, 64, 65, 120};
		int have = 0;
		send_item(OP_RESTART, 8'h00);
		foreach (lens[i]) begin
			send_bytes(lens[i] - have);
			have = lens[i];
			send_item(OP_DIGEST, 8'($urandom));
		end
	endtask

	// mostly messages with digest reads along the way, some noise ops
	task automatic test_random_stream();
		int sent = 0;
		int r;
		while (sent < 95) begin
			r = $urandom_range(0, 99);
			if (r < 80) send_item(OP_ABSORB, 8'($urandom));
			else if (r < 92) send_item(OP_DIGEST, 8'($urandom));
			else if (r < 97) send_item(OP_RESTART, 8'($urandom));
			else send_item(OP_UNUSED, 8'($urandom));
			sent++;
			if (sent == 70) calm = 1'b1;
		end
	endtask

	// bit count wrap cannot be reached by streaming, so it stays with the model

	initial begin
		restart_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_padding_edges();
		test_random_stream();
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_beats.size() == 0)
			$display("md4_message_digest verification clean");
		else
			$display("md4_message_digest verification failed");
		$finish;
	end
endmodule
